/* sv/spq_pkg.sv */
// shared types and codes for the sorted priority queue
// no dependencies; imported by the cell, the top level and the checker
package spq_pkg;

    // operation codes on the func field
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // status codes on the result
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // one stored pair
    typedef struct packed {
        logic signed [31:0] item;
        logic signed [31:0] prio;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;  // insert the new pair, ripple the lower part down
        logic deq;  // drop the head, every cell takes its right neighbour
    } t_cell_ctrl;

endpackage

/* sv/spq_cell.sv */
// one cell of the sorted chain: holds a pair, compares it with the new pair
// depends on spq_pkg
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_left,
    input  spq_pkg::t_entry     i_right,
    input  logic                i_left_ge,
    input  logic                i_occupied,
    output logic                o_ge,
    output spq_pkg::t_entry     o_entry,
    output spq_pkg::t_entry     o_next
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // stored pair stays ahead of the new one when its priority is not lower
    assign o_ge = i_occupied && (r_entry.prio >= i_new.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (o_ge) begin
                n_entry = r_entry;
            end else if (i_left_ge) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

/* sv/sorted_priority_queue_unit.sv */
// top level of the sorted priority queue: control, fill count, result register
// depends on spq_pkg and spq_cell
//
// usage
//  - request channel: i_valid / o_stall with i_func, i_item_in, i_priority_in;
//    func enqueue inserts the pair behind every stored pair of greater or
//    equal priority, func dequeue removes the head pair
//  - result channel: o_valid / i_stall, exactly one result per request,
//    carrying the popped pair, a status code, the new head item and the
//    occupancy (count masked to five bits)
//  - one request per cycle while o_stall is low: every cell compares its
//    priority with the new one in parallel and shifts in the same cycle,
//    so the cells set the rate; the result is registered on acceptance
//  - a full queue drops an enqueue with overflow status, an empty queue
//    answers a dequeue with underflow status; neither changes the contents
//  - when the receiver stalls, the result register holds and o_stall is
//    raised, so no further request is taken until the result leaves
//  - reset clears the fill count and the result valid flag only; the
//    cell contents are never read before they are written
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic signed [31:0] i_item_in,
    input  logic signed [31:0] i_priority_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_popped_item,
    output logic signed [31:0] o_popped_priority,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_head_item,
    output logic [4:0]         o_occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // fill count and result register
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_valid;
    logic signed [31:0] r_popped_item;
    logic signed [31:0] r_popped_priority;
    logic [1:0]         r_status;
    logic signed [31:0] r_head_item;
    logic [CW-1:0]      r_occ;

    // chain wiring
    t_entry     w_new;
    t_cell_ctrl w_ctrl;
    t_entry     w_entry [CAPACITY];
    t_entry     w_next  [CAPACITY];
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_occupied;

    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic [CW+4:0] w_occ_ext;

    // a request is taken whenever the result register is free or draining
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_new.item = i_item_in;
    assign w_new.prio = i_priority_in;

    assign w_ctrl.enq = w_accept && (i_func == FUNC_ENQ) && !w_full;
    assign w_ctrl.deq = w_accept && (i_func == FUNC_DEQ) && !w_empty;

    // cell chain, head at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_ge;

        assign w_occupied[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_first
            // the head cell takes the new pair whenever it is not ahead of it
            assign w_left    = w_new;
            assign w_left_ge = 1'b1;
        end else begin : g_inner
            assign w_left    = w_entry[g-1];
            assign w_left_ge = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // contents past the count are never read
            assign w_right = w_new;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_new      (w_new),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_left_ge  (w_left_ge),
            .i_occupied (w_occupied[g]),
            .o_ge       (w_ge[g]),
            .o_entry    (w_entry[g]),
            .o_next     (w_next[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped_item     <= w_ctrl.deq ? w_entry[0].item : 32'sd0;
            r_popped_priority <= w_ctrl.deq ? w_entry[0].prio : 32'sd0;
            if (i_func == FUNC_DEQ && w_empty) begin
                r_status <= STATUS_UNDERFLOW;
            end else if (i_func == FUNC_ENQ && w_full) begin
                r_status <= STATUS_OVERFLOW;
            end else begin
                r_status <= STATUS_OK;
            end
            r_head_item <= (n_count != '0) ? w_next[0].item : 32'sd0;
            r_occ       <= n_count;
        end
    end

    // occupancy shows the count masked to five bits
    assign w_occ_ext = {5'd0, r_occ};

    assign o_valid           = r_valid;
    assign o_popped_item     = r_popped_item;
    assign o_popped_priority = r_popped_priority;
    assign o_status          = r_status;
    assign o_head_item       = r_head_item;
    assign o_occupancy       = w_occ_ext[4:0];

endmodule

/* sv/spq_checker.sv */
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg
module spq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_popped_item,
    input logic signed [31:0] o_popped_priority,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_head_item,
    input logic [4:0]         o_occupancy
);
    import spq_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_popped_item)
            && $stable(o_status) && $stable(o_occupancy))
        else $error("stalled result changed");

    // every accepted request yields a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted request gave no result");

    // underflow leaves an empty queue and pops nothing
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_UNDERFLOW |->
            o_popped_item == 32'sd0 && o_popped_priority == 32'sd0
            && o_occupancy == 5'd0 && o_head_item == 32'sd0)
        else $error("underflow result not empty");

    // a dropped enqueue pops nothing
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_OVERFLOW |->
            o_popped_item == 32'sd0 && o_popped_priority == 32'sd0)
        else $error("overflow result popped a pair");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_popped_item     (o_popped_item),
    .o_popped_priority (o_popped_priority),
    .o_status          (o_status),
    .o_head_item       (o_head_item),
    .o_occupancy       (o_occupancy)
);

/* dv/sorted_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for sorted_priority_queue_unit: directed and random requests
// with random gaps and stalls, each result checked against a queue predictor kept here
// depends on spq_pkg and the sorted_priority_queue_unit rtl
module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // well above the longest correct quiet stretch
    localparam int SETTLE_CYCLES  = 8;     // result is registered in the cycle after acceptance
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

    // one expected result, field for field as it leaves the block
    typedef struct {
        logic signed [31:0] popped_item;
        logic signed [31:0] popped_priority;
        logic [1:0]         status;
        logic signed [31:0] head_item;
        logic [4:0]         occupancy;
    } t_queue_result;

    // dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_func = FUNC_ENQ;
    logic signed [31:0] i_item_in = '0;
    logic signed [31:0] i_priority_in = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_popped_item;
    logic signed [31:0] o_popped_priority;
    logic [1:0]         o_status;
    logic signed [31:0] o_head_item;
    logic [4:0]         o_occupancy;

    // predictor state: sorted copy of the queue, head at index 0
    logic signed [31:0] queue_items [CAPACITY];
    logic signed [31:0] queue_prios [CAPACITY];
    int                 queue_fill = 0;

    // results still owed by the block, oldest first
    t_queue_result      pending_results [$];

    // run statistics
    int enqueue_count   = 0;
    int overflow_count  = 0;
    int dequeue_count   = 0;
    int underflow_count = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int idle_cycles     = 0;

    // traffic shaping shared between the test tasks and the stall driver
    bit sender_eager   = 1'b0;
    bit receiver_eager = 1'b0;
    bit hold_request   = 1'b0;
    int hold_count     = 0;

    sorted_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_item_in        (i_item_in),
        .i_priority_in    (i_priority_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_popped_item    (o_popped_item),
        .o_popped_priority(o_popped_priority),
        .o_status         (o_status),
        .o_head_item      (o_head_item),
        .o_occupancy      (o_occupancy)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // apply one accepted request to the sorted copy and return what the block owes
    function automatic t_queue_result apply_queue_op(input logic func,
                                                     input logic signed [31:0] item,
                                                     input logic signed [31:0] prio);
        t_queue_result res;
        int slot;
        int k;
        res = '{default: '0};
        res.status = STATUS_OK;
        if (func == FUNC_ENQ) begin
            if (queue_fill >= CAPACITY) begin
                // full queue drops the pair untouched
                res.status = STATUS_OVERFLOW;
                overflow_count++;
            end else begin
                // land behind every pair of greater or equal priority, so ties stay fifo
                slot = 0;
                while (slot < queue_fill && queue_prios[slot] >= prio)
                    slot++;
                for (k = queue_fill; k > slot; k--) begin
                    queue_items[k] = queue_items[k - 1];
                    queue_prios[k] = queue_prios[k - 1];
                end
                queue_items[slot] = item;
                queue_prios[slot] = prio;
                queue_fill++;
                enqueue_count++;
            end
        end else begin
            if (queue_fill == 0) begin
                res.status = STATUS_UNDERFLOW;
                underflow_count++;
            end else begin
                res.popped_item     = queue_items[0];
                res.popped_priority = queue_prios[0];
                for (k = 1; k < queue_fill; k++) begin
                    queue_items[k - 1] = queue_items[k];
                    queue_prios[k - 1] = queue_prios[k];
                end
                queue_fill--;
                dequeue_count++;
            end
        end
        res.head_item = (queue_fill != 0) ? queue_items[0] : '0;
        res.occupancy = 5'(queue_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] random_item();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // a narrow band gives plenty of ties, the rest spreads over the full range
    function automatic logic signed [31:0] random_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 7) - 4;
        else if (r < 70)
            return $urandom;
        else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       return MOST_NEG;
                1:       return MOST_POS;
                2:       return '0;
                default: return -1;
            endcase
        end else if (r < 93)
            return MOST_POS - $urandom_range(0, 3);
        else
            return MOST_NEG + $urandom_range(0, 3);
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request, hold it until taken, then record what it should produce
    task automatic send_request(input logic func, input logic signed [31:0] item,
                                input logic signed [31:0] prio);
        int gap;
        gap = sender_eager ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_item_in     <= item;
        i_priority_in <= prio;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        pending_results.push_back(apply_queue_op(func, item, prio));
    endtask

    // stop offering and let every owed result come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result side: stall driver
    // ------------------------------------------------------------------

    // random stall bursts, quiet stretches when eager, and a counted hold-off on request
    initial begin
        int len;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge i_clk);
                hold_request = 1'b0;
            end else if (receiver_eager) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < 35);
                len = pick_gap();
                if (len == 0)
                    len = 1;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s at %0t: expected 0x%h, got 0x%h",
                         name, $realtime, want, got);
        end
    endfunction

    // every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result at %0t: no request outstanding", $realtime);
            end else begin
                want = pending_results.pop_front();
                check_field("popped_item",     want.popped_item,     o_popped_item);
                check_field("popped_priority", want.popped_priority, o_popped_priority);
                check_field("status",          32'(want.status),     32'(o_status));
                check_field("head_item",       want.head_item,       o_head_item);
                check_field("occupancy",       32'(want.occupancy),  32'(o_occupancy));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles in which neither channel moves anything
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results owed",
                     idle_cycles, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // dequeue straight after reset must underflow, whatever the ignored fields hold
    task automatic test_dequeue_empty();
        send_request(FUNC_DEQ, MOST_NEG, MOST_POS);
        send_request(FUNC_DEQ, MOST_POS, MOST_NEG);
    endtask

    // extremes of priority and item, plus ties that must leave in arrival order
    task automatic test_priority_order();
        send_request(FUNC_ENQ, MOST_POS, MOST_NEG);
        send_request(FUNC_ENQ, MOST_NEG, MOST_POS);
        send_request(FUNC_ENQ, -1, 0);
        send_request(FUNC_ENQ, 0, 0);
        send_request(FUNC_ENQ, 1, MOST_POS);
        send_request(FUNC_ENQ, 2, MOST_NEG);
    endtask

    // fill to capacity, overflow even with the top priority, then pop a few
    task automatic test_full_queue();
        int n;
        for (n = queue_fill; n < CAPACITY; n++)
            send_request(FUNC_ENQ, random_item(), random_priority());
        send_request(FUNC_ENQ, MOST_POS, MOST_POS);
        send_request(FUNC_ENQ, MOST_NEG, MOST_NEG);
        repeat (3) send_request(FUNC_DEQ, random_item(), random_priority());
        drain_results();
    endtask

    // phases of enqueue or dequeue bias so the queue swings between empty and full
    task automatic test_random_traffic(input int count);
        int n;
        int enq_bias;
        logic func;
        enq_bias = 50;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0:       enq_bias = 15;
                    1:       enq_bias = 50;
                    2:       enq_bias = 85;
                    default: enq_bias = 97;
                endcase
                sender_eager   = ($urandom_range(0, 3) == 0);
                receiver_eager = ($urandom_range(0, 3) == 0);
            end
            func = ($urandom_range(0, 99) < enq_bias) ? FUNC_ENQ : FUNC_DEQ;
            send_request(func, random_item(), random_priority());
        end
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
        drain_results();
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the result register fills and the block stalls its input
    task automatic test_receiver_hold_off();
        int n;
        logic func;
        sender_eager = 1'b1;
        hold_request = 1'b1;
        // start offering only once the hold-off is under way
        wait (hold_count > 0);
        for (n = 0; n < 48; n++) begin
            func = ($urandom_range(0, 99) < 60) ? FUNC_ENQ : FUNC_DEQ;
            send_request(func, random_item(), random_priority());
        end
        sender_eager = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_dequeue_empty();
        test_priority_order();
        test_full_queue();
        test_random_traffic(1600);
        test_receiver_hold_off();

        // anything still owed at this point is a failure
        mismatch_count += pending_results.size();

        $display("covered %0d stored enqueues, %0d overflows, %0d dequeues, %0d underflows",
                 enqueue_count, overflow_count, dequeue_count, underflow_count);
        $display("%0d results checked under random gaps, stalls and a long hold-off, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
